FILE: hdl/pcss_pkg.sv
// Shared types and constants for the point cluster spread statistics block.
package pcss_pkg;

  localparam int COORD_W       = 32;
  localparam int SUM_W         = 48;   // coordinate sums, enough for 4096 full-scale points
  localparam int CNT_W         = 13;   // point count carried in a job, up to 4096
  localparam int SCALE_W       = 16;
  localparam int DATA_W        = 48;   // widest configuration register
  localparam int CFG_IDX_W     = 1;
  localparam int MESH_W        = 34;
  localparam int RAD_W         = 48;
  localparam int PC_W          = 9;
  localparam int DIV_NUM_W     = 80;
  localparam int DIV_DEN_W     = 49;
  localparam int SQ_OP_W       = 70;
  localparam int SQ_ROOT_W     = 35;
  localparam int DEFAULT_MAX_POINTS = 256;

  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_SCALE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_SCAT = 1'd1;

  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam logic [RAD_W-1:0]   SAT48       = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] pos_z;
    logic                      last_point;
  } point_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] mean_x;
    logic signed [COORD_W-1:0] mean_y;
    logic signed [COORD_W-1:0] mean_z;
    logic [MESH_W-1:0]         mean_nn_distance;
    logic [RAD_W-1:0]          equivalent_radius;
    logic [RAD_W-1:0]          scattering;
    logic [PC_W-1:0]           point_count;
    logic                      overflowed;
  } result_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } coord3_t;

  // One closed cluster handed from the loader to the evaluator
  typedef struct packed {
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum_x;
    logic signed [SUM_W-1:0] sum_y;
    logic signed [SUM_W-1:0] sum_z;
    logic                    dropped;
  } job_t;

endpackage

FILE: hdl/pcss_point_ram.sv
// Point store: one write port, one registered read port.
module pcss_point_ram #(
  parameter int MAX_POINTS = pcss_pkg::DEFAULT_MAX_POINTS,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  pcss_pkg::coord3_t wdata,
  input  logic [AW-1:0]    raddr,
  output pcss_pkg::coord3_t rdata
);

  pcss_pkg::coord3_t mem [MAX_POINTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/pcss_divider.sv
// Restoring divider, one quotient bit per cycle.
module pcss_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [pcss_pkg::DIV_NUM_W-1:0] num,
  input  logic [pcss_pkg::DIV_DEN_W-1:0] den,
  output logic                           done,
  output logic [pcss_pkg::DIV_NUM_W-1:0] quo
);

  localparam int NW = pcss_pkg::DIV_NUM_W;
  localparam int DW = pcss_pkg::DIV_DEN_W;
  localparam int CNTW = $clog2(NW);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [NW-1:0]   dvd;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   den_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            fits;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem, dvd[NW-1]};
    rem_sub = rem_sh - {1'b0, den_r};
    fits    = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift into the dividend register from the bottom
  always_ff @(posedge clk) begin
    if (go) begin
      dvd   <= num;
      rem   <= '0;
      den_r <= den;
    end else if (run) begin
      dvd <= {dvd[NW-2:0], fits};
      rem <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
    end
  end

  assign quo = dvd;

endmodule

FILE: hdl/pcss_sqrt.sv
// Integer square root, digit by digit, one root bit per cycle.
module pcss_sqrt (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           go,
  input  logic [pcss_pkg::SQ_OP_W-1:0]   op,
  output logic                           done,
  output logic [pcss_pkg::SQ_ROOT_W-1:0] root
);

  localparam int OW   = pcss_pkg::SQ_OP_W;
  localparam int RW   = pcss_pkg::SQ_ROOT_W;
  localparam int REMW = RW + 3;
  localparam int CNTW = $clog2(RW);

  logic            run;
  logic [CNTW-1:0] cnt;
  logic [OW-1:0]   op_r;
  logic [REMW-1:0] rem;
  logic [REMW-1:0] rem_sh;
  logic [REMW-1:0] trial;
  logic            fits;

  always_comb begin
    rem_sh = {rem[REMW-3:0], op_r[OW-1:OW-2]};
    trial  = REMW'({root, 2'b01});
    fits   = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNTW'(RW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      op_r <= op;
      rem  <= '0;
      root <= '0;
    end else if (run) begin
      op_r <= {op_r[OW-3:0], 2'b00};
      rem  <= fits ? rem_sh - trial : rem_sh;
      root <= {root[RW-2:0], fits};
    end
  end

endmodule

FILE: hdl/pcss_front.sv
// Loader: takes points, fills the store, keeps sums and queues closed clusters.
module pcss_front #(
  parameter int MAX_POINTS = pcss_pkg::DEFAULT_MAX_POINTS,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pcss_pkg::point_t   point,
  input  logic               back_idle,
  output logic               ram_we,
  output logic [AW-1:0]      ram_waddr,
  output pcss_pkg::coord3_t  ram_wdata,
  output logic               job_valid,
  output pcss_pkg::job_t     job,
  input  logic               job_pop
);

  logic                              accept;
  logic                              room;
  logic [CW-1:0]                     held;
  logic [CW-1:0]                     held_next;
  logic signed [pcss_pkg::SUM_W-1:0] sum_x, sum_y, sum_z;
  logic signed [pcss_pkg::SUM_W-1:0] sum_x_next, sum_y_next, sum_z_next;
  logic                              dropped;
  logic                              dropped_next;

  // the store is shared with the evaluator, so hold off while a cluster is open there
  assign busy   = job_valid | ~back_idle;
  assign accept = start & ~busy;
  assign room   = held != CW'(MAX_POINTS);

  assign ram_we      = accept & room;
  assign ram_waddr   = held[AW-1:0];
  assign ram_wdata.x = point.pos_x;
  assign ram_wdata.y = point.pos_y;
  assign ram_wdata.z = point.pos_z;

  always_comb begin
    held_next    = held;
    sum_x_next   = sum_x;
    sum_y_next   = sum_y;
    sum_z_next   = sum_z;
    dropped_next = dropped;
    if (room) begin
      held_next  = held + 1'b1;
      sum_x_next = sum_x + pcss_pkg::SUM_W'(point.pos_x);
      sum_y_next = sum_y + pcss_pkg::SUM_W'(point.pos_y);
      sum_z_next = sum_z + pcss_pkg::SUM_W'(point.pos_z);
    end else begin
      dropped_next = 1'b1;
    end
  end

  // accumulate, and on the closing point push the cluster into the one-entry queue
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      sum_z     <= '0;
      dropped   <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        job_valid <= 1'b0;
      end
      if (accept) begin
        if (point.last_point) begin
          held      <= '0;
          sum_x     <= '0;
          sum_y     <= '0;
          sum_z     <= '0;
          dropped   <= 1'b0;
          job_valid <= 1'b1;
        end else begin
          held    <= held_next;
          sum_x   <= sum_x_next;
          sum_y   <= sum_y_next;
          sum_z   <= sum_z_next;
          dropped <= dropped_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && point.last_point) begin
      job.count   <= pcss_pkg::CNT_W'(held_next);
      job.sum_x   <= sum_x_next;
      job.sum_y   <= sum_y_next;
      job.sum_z   <= sum_z_next;
      job.dropped <= dropped_next;
    end
  end

endmodule

FILE: hdl/pcss_back.sv
// Evaluator: centroid, all-pairs nearest search, radius and scattering.
module pcss_back #(
  parameter int MAX_POINTS = pcss_pkg::DEFAULT_MAX_POINTS,
  localparam int AW = $clog2(MAX_POINTS),
  localparam int CW = $clog2(MAX_POINTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            job_valid,
  input  pcss_pkg::job_t                  job,
  output logic                            job_pop,
  output logic                            idle,
  output logic [AW-1:0]                   ram_raddr,
  input  pcss_pkg::coord3_t               ram_rdata,
  input  logic [pcss_pkg::SCALE_W-1:0]    radius_scale,
  input  logic [pcss_pkg::RAD_W-1:0]      default_scattering,
  output logic                            result_valid,
  output pcss_pkg::result_t               result
);

  localparam int SUM_W = pcss_pkg::SUM_W;
  localparam int D2_W  = 68;
  localparam int NN_W  = 48;
  localparam int PR_W  = 50;
  localparam int SN_W  = 31;
  localparam int PP_W  = 56;
  localparam int W_W   = 82;

  typedef enum logic [4:0] {
    ST_IDLE, ST_MEAN_GO, ST_MEAN_WAIT, ST_ROW_RD, ST_ROW_LATCH, ST_SWEEP,
    ST_NN_GO, ST_NN_WAIT, ST_MESH_GO, ST_MESH_WAIT, ST_SQN_GO, ST_SQN_WAIT,
    ST_MUL_A, ST_MUL_B, ST_MUL_C, ST_MUL_D, ST_SCAT_GO, ST_SCAT_WAIT, ST_OUT
  } state_t;

  state_t state;

  pcss_pkg::job_t                        jb;
  logic [CW-1:0]                         cnt;
  logic [1:0]                            ax;
  logic [CW-1:0]                         i;
  logic [CW-1:0]                         j;
  logic                                  j_live;
  logic signed [pcss_pkg::COORD_W-1:0]   mean_x, mean_y, mean_z;
  pcss_pkg::coord3_t                     pi;
  logic [NN_W-1:0]                       nn_sum;
  logic [pcss_pkg::MESH_W-1:0]           mesh;
  logic [SN_W-1:0]                       sqrt_n;
  logic [PR_W-1:0]                       prod;
  logic [PP_W-1:0]                       w_lo, w_hi;
  logic [W_W-1:0]                        w_sum;
  logic [pcss_pkg::RAD_W-1:0]            radius;
  logic [pcss_pkg::RAD_W-1:0]            scat;

  // sweep pipeline
  logic                                  issue;
  logic                                  v1, v2, v3, v4;
  logic                                  m1, m2, m3, m4;
  logic                                  sk1, sk2, sk3, sk4;
  pcss_pkg::coord3_t                     opnd;
  logic signed [32:0]                    dfx, dfy, dfz;
  logic [32:0]                           adx, ady, adz;
  logic [65:0]                           sqx, sqy, sqz;
  logic [D2_W-1:0]                       d4;
  logic [D2_W-1:0]                       best;
  logic                                  have;
  logic [pcss_pkg::DIV_NUM_W-1:0]        spread;

  // shared units
  logic                                  div_go, div_done;
  logic [pcss_pkg::DIV_NUM_W-1:0]        div_num, div_quo;
  logic [pcss_pkg::DIV_DEN_W-1:0]        div_den;
  logic                                  sq_go, sq_done;
  logic [pcss_pkg::SQ_OP_W-1:0]          sq_op;
  logic [pcss_pkg::SQ_ROOT_W-1:0]        sq_root;

  logic signed [SUM_W-1:0]               sum_sel;
  logic                                  sum_neg;
  logic [SUM_W-1:0]                      sum_mag;
  logic [pcss_pkg::COORD_W-1:0]          q32;
  logic [pcss_pkg::COORD_W-1:0]          mean_val;

  assign idle    = state == ST_IDLE;
  assign job_pop = idle & job_valid;
  assign issue   = (state == ST_SWEEP) & j_live;
  assign ram_raddr = (state == ST_ROW_RD) ? i[AW-1:0] : j[AW-1:0];

  // sign and magnitude of the sum being averaged
  always_comb begin
    case (ax)
      2'd0:    sum_sel = jb.sum_x;
      2'd1:    sum_sel = jb.sum_y;
      default: sum_sel = jb.sum_z;
    endcase
    sum_neg  = sum_sel[SUM_W-1];
    sum_mag  = sum_neg ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);
    q32      = div_quo[pcss_pkg::COORD_W-1:0];
    mean_val = sum_neg ? -q32 : q32;
  end

  // operand selection for the divider and the root unit
  always_comb begin
    div_go  = 1'b0;
    div_num = pcss_pkg::DIV_NUM_W'(sum_mag);
    div_den = pcss_pkg::DIV_DEN_W'(cnt);
    sq_go   = 1'b0;
    sq_op   = pcss_pkg::SQ_OP_W'(best);
    case (state)
      ST_MEAN_GO: div_go = 1'b1;
      ST_MESH_GO: begin
        div_go  = 1'b1;
        div_num = pcss_pkg::DIV_NUM_W'(nn_sum);
      end
      ST_SCAT_GO: begin
        div_go  = 1'b1;
        div_num = spread;
        div_den = pcss_pkg::DIV_DEN_W'(radius) + 1'b1;
      end
      ST_NN_GO: sq_go = 1'b1;
      ST_SQN_GO: begin
        sq_go = 1'b1;
        sq_op = pcss_pkg::SQ_OP_W'({cnt, 48'd0});
      end
      default: ;
    endcase
  end

  pcss_divider u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  pcss_sqrt u_sqrt (
    .clk  (clk),
    .rst  (rst),
    .go   (sq_go),
    .op   (sq_op),
    .done (sq_done),
    .root (sq_root)
  );

  assign w_sum = (W_W'(w_hi) << 25) + W_W'(w_lo);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      j_live <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (job_valid) begin
            jb    <= job;
            cnt   <= job.count[CW-1:0];
            ax    <= 2'd0;
            state <= ST_MEAN_GO;
          end
        end
        ST_MEAN_GO: state <= ST_MEAN_WAIT;
        ST_MEAN_WAIT: begin
          if (div_done) begin
            case (ax)
              2'd0:    mean_x <= mean_val;
              2'd1:    mean_y <= mean_val;
              default: mean_z <= mean_val;
            endcase
            ax <= ax + 1'b1;
            if (ax != 2'd2) begin
              state <= ST_MEAN_GO;
            end else if (cnt == CW'(1)) begin
              mesh   <= '0;
              radius <= '0;
              scat   <= default_scattering;
              state  <= ST_OUT;
            end else begin
              i      <= '0;
              nn_sum <= '0;
              state  <= ST_ROW_RD;
            end
          end
        end
        ST_ROW_RD: state <= ST_ROW_LATCH;
        ST_ROW_LATCH: begin
          pi     <= ram_rdata;
          j      <= '0;
          j_live <= 1'b1;
          state  <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (j_live) begin
            j <= j + 1'b1;
            if (j == cnt) begin
              j_live <= 1'b0;
            end
          end else if (!v1 && !v2 && !v3 && !v4) begin
            state <= ST_NN_GO;
          end
        end
        ST_NN_GO: state <= ST_NN_WAIT;
        ST_NN_WAIT: begin
          if (sq_done) begin
            nn_sum <= nn_sum + NN_W'(sq_root);
            i      <= i + 1'b1;
            state  <= (i + 1'b1 == cnt) ? ST_MESH_GO : ST_ROW_RD;
          end
        end
        ST_MESH_GO: state <= ST_MESH_WAIT;
        ST_MESH_WAIT: begin
          if (div_done) begin
            mesh  <= div_quo[pcss_pkg::MESH_W-1:0];
            state <= ST_SQN_GO;
          end
        end
        ST_SQN_GO: state <= ST_SQN_WAIT;
        ST_SQN_WAIT: begin
          if (sq_done) begin
            sqrt_n <= sq_root[SN_W-1:0];
            state  <= ST_MUL_A;
          end
        end
        ST_MUL_A: begin
          prod  <= PR_W'(radius_scale * mesh);
          state <= ST_MUL_B;
        end
        ST_MUL_B: begin
          w_lo  <= PP_W'(prod[24:0] * sqrt_n);
          state <= ST_MUL_C;
        end
        ST_MUL_C: begin
          w_hi  <= PP_W'(prod[PR_W-1:25] * sqrt_n);
          state <= ST_MUL_D;
        end
        ST_MUL_D: begin
          // drop the Q.24 and Q.8 fraction bits, saturate at 48 bits
          radius <= (|w_sum[W_W-1:80]) ? pcss_pkg::SAT48 : w_sum[79:32];
          state  <= ST_SCAT_GO;
        end
        ST_SCAT_GO: state <= ST_SCAT_WAIT;
        ST_SCAT_WAIT: begin
          if (div_done) begin
            scat  <= (|div_quo[pcss_pkg::DIV_NUM_W-1:48]) ? pcss_pkg::SAT48 : div_quo[47:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end

  // sweep stages: operand select and difference, absolute values, squares, sum, then nearest compare or spread sum
  always_comb begin
    if (m1) begin
      opnd.x = mean_x;
      opnd.y = mean_y;
      opnd.z = mean_z;
    end else begin
      opnd = ram_rdata;
    end
    dfx = {pi.x[31], pi.x} - {opnd.x[31], opnd.x};
    dfy = {pi.y[31], pi.y} - {opnd.y[31], opnd.y};
    dfz = {pi.z[31], pi.z} - {opnd.z[31], opnd.z};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    m1  <= j == cnt;
    sk1 <= j == i;
    m2  <= m1;
    sk2 <= sk1;
    adx <= dfx[32] ? 33'(-dfx) : 33'(dfx);
    ady <= dfy[32] ? 33'(-dfy) : 33'(dfy);
    adz <= dfz[32] ? 33'(-dfz) : 33'(dfz);
    m3  <= m2;
    sk3 <= sk2;
    sqx <= adx * adx;
    sqy <= ady * ady;
    sqz <= adz * adz;
    m4  <= m3;
    sk4 <= sk3;
    d4  <= D2_W'(sqx) + D2_W'(sqy) + D2_W'(sqz);
    if (state == ST_ROW_LATCH) begin
      have <= 1'b0;
      if (i == '0) begin
        spread <= '0;
      end
    end else if (v4) begin
      if (m4) begin
        spread <= spread + pcss_pkg::DIV_NUM_W'(d4);
      end else if (!sk4 && (!have || d4 < best)) begin
        best <= d4;
        have <= 1'b1;
      end
    end
  end

  // result port
  assign result_valid             = state == ST_OUT;
  assign result.mean_x            = mean_x;
  assign result.mean_y            = mean_y;
  assign result.mean_z            = mean_z;
  assign result.mean_nn_distance  = mesh;
  assign result.equivalent_radius = radius;
  assign result.scattering        = scat;
  assign result.point_count       = pcss_pkg::PC_W'(cnt);
  assign result.overflowed        = jb.dropped;

  a_strobe_single: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid)
    else $error("result strobe longer than one cycle");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> cnt != '0)
    else $error("result with empty cluster");

  a_pipe_in_sweep: assert property (@(posedge clk) disable iff (rst)
    (v1 || v2 || v3 || v4) |-> state == ST_SWEEP)
    else $error("distance pipeline active outside the sweep");

endmodule

FILE: hdl/point_cluster_spread_stats.sv
// Top level: configuration registers, loader, point store and evaluator.
//
//  port group                          dir  transfer
//  start / busy / point                in   point taken when start & !busy
//  cfg_we / cfg_index / cfg_data       in   register written when cfg_we
//  result_valid / result               out  one-cycle strobe, no back-pressure
//
// The closing point hands the cluster to the evaluator and busy stays high
// until its result has been strobed. The all-pairs distance sweep reads the
// point store through its single read port, one point a cycle per row.
// Reset is synchronous; it empties the cluster and restores the registers.
// The result cannot be stalled; it is valid for exactly one cycle.
module point_cluster_spread_stats #(
  parameter int MAX_POINTS = pcss_pkg::DEFAULT_MAX_POINTS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  pcss_pkg::point_t                  point,
  input  logic                              cfg_we,
  input  logic [pcss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [pcss_pkg::DATA_W-1:0]       cfg_data,
  output logic                              result_valid,
  output pcss_pkg::result_t                 result
);

  localparam int AW = $clog2(MAX_POINTS);

  logic [pcss_pkg::SCALE_W-1:0] radius_scale;
  logic [pcss_pkg::RAD_W-1:0]   default_scattering;
  logic                         back_idle;
  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [AW-1:0]                ram_raddr;
  pcss_pkg::coord3_t            ram_wdata;
  pcss_pkg::coord3_t            ram_rdata;
  logic                         job_valid;
  logic                         job_pop;
  pcss_pkg::job_t               job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_scale       <= pcss_pkg::SCALE_RESET;
      default_scattering <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pcss_pkg::REG_RADIUS_SCALE: radius_scale <= cfg_data[pcss_pkg::SCALE_W-1:0];
        pcss_pkg::REG_DEFAULT_SCAT: default_scattering <= cfg_data[pcss_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  pcss_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .point     (point),
    .back_idle (back_idle),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  pcss_point_ram #(.MAX_POINTS(MAX_POINTS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  pcss_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .job_valid          (job_valid),
    .job                (job),
    .job_pop            (job_pop),
    .idle               (back_idle),
    .ram_raddr          (ram_raddr),
    .ram_rdata          (ram_rdata),
    .radius_scale       (radius_scale),
    .default_scattering (default_scattering),
    .result_valid       (result_valid),
    .result             (result)
  );

endmodule

FILE: dv/tb_top.sv
// Testbench for the point cluster spread statistics block, with its scoreboard.
`timescale 1ns / 100ps

module tb_top;

  localparam int CAPACITY   = pcss_pkg::DEFAULT_MAX_POINTS;
  localparam int WDOG_LIMIT = 400000;

  // Scoreboard: tracks the open cluster and holds the statistics still due
  class cluster_scoreboard;
    logic signed [pcss_pkg::COORD_W-1:0] held_x [CAPACITY];
    logic signed [pcss_pkg::COORD_W-1:0] held_y [CAPACITY];
    logic signed [pcss_pkg::COORD_W-1:0] held_z [CAPACITY];
    int                                  held;
    bit                                  dropped;
    longint                              acc_x, acc_y, acc_z;
    logic [pcss_pkg::SCALE_W-1:0]        scale;
    logic [pcss_pkg::RAD_W-1:0]          single_scat;
    pcss_pkg::result_t                   expected_stats[$];
    int                                  errors;

    function new();
      held = 0; dropped = 0; acc_x = 0; acc_y = 0; acc_z = 0;
      scale = pcss_pkg::SCALE_RESET; single_scat = '0; errors = 0;
    endfunction

    function void set_reg(logic [pcss_pkg::CFG_IDX_W-1:0] idx,
                          logic [pcss_pkg::DATA_W-1:0] data);
      if (idx == pcss_pkg::REG_RADIUS_SCALE) scale = data[pcss_pkg::SCALE_W-1:0];
      else if (idx == pcss_pkg::REG_DEFAULT_SCAT) single_scat = data[pcss_pkg::RAD_W-1:0];
    endfunction

    // Floor square root of a wide unsigned value
    static function logic [63:0] root_floor(logic [127:0] v);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 40; b >= 0; b--) begin
        c = r | (64'd1 << b);
        if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
    endfunction

    static function logic [127:0] sq_dist(longint ax, longint ay, longint az,
                                          longint bx, longint by, longint bz);
      longint d [3];
      logic [127:0] s;
      d[0] = ax - bx; d[1] = ay - by; d[2] = az - bz;
      s = '0;
      for (int k = 0; k < 3; k++) begin
        if (d[k] < 0) d[k] = -d[k];
        s += {64'd0, d[k]} * {64'd0, d[k]};
      end
      return s;
    endfunction

    function void note_point(pcss_pkg::point_t p);
      longint mx, my, mz;
      logic [127:0] best, dd, spread, w, q;
      logic [63:0] nn_sum, mesh, root_n, radius;
      pcss_pkg::result_t r;
      if (held < CAPACITY) begin
        held_x[held] = p.pos_x; held_y[held] = p.pos_y; held_z[held] = p.pos_z;
        acc_x += longint'(p.pos_x); acc_y += longint'(p.pos_y); acc_z += longint'(p.pos_z);
        held++;
      end else begin
        dropped = 1;
      end
      if (!p.last_point) return;

      mx = acc_x / longint'(held);
      my = acc_y / longint'(held);
      mz = acc_z / longint'(held);
      mesh = '0; radius = '0;
      if (held > 1) begin
        nn_sum = '0; spread = '0;
        for (int i = 0; i < held; i++) begin
          best = '1;
          for (int j = 0; j < held; j++) begin
            if (j == i) continue;
            dd = sq_dist(held_x[i], held_y[i], held_z[i], held_x[j], held_y[j], held_z[j]);
            if (dd < best) best = dd;
          end
          nn_sum += root_floor(best);
          spread += sq_dist(held_x[i], held_y[i], held_z[i], mx, my, mz);
        end
        mesh   = nn_sum / held;
        root_n = root_floor(128'(held) << 48);
        w      = 128'(scale) * 128'(mesh) * 128'(root_n);
        w      = w >> 32;
        radius = (w > 128'(pcss_pkg::SAT48)) ? 64'(pcss_pkg::SAT48) : w[63:0];
        q      = spread / (128'(radius) + 128'd1);
        r.scattering = (q > 128'(pcss_pkg::SAT48)) ? pcss_pkg::SAT48
                                                   : q[pcss_pkg::RAD_W-1:0];
      end else begin
        r.scattering = single_scat;
      end
      r.mean_x = mx[31:0]; r.mean_y = my[31:0]; r.mean_z = mz[31:0];
      r.mean_nn_distance  = mesh[pcss_pkg::MESH_W-1:0];
      r.equivalent_radius = radius[pcss_pkg::RAD_W-1:0];
      r.point_count       = held[pcss_pkg::PC_W-1:0];
      r.overflowed        = dropped;
      expected_stats.push_back(r);
      held = 0; dropped = 0; acc_x = 0; acc_y = 0; acc_z = 0;
    endfunction

    function void cmp(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch: expected %h, got %h", $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(pcss_pkg::result_t got);
      pcss_pkg::result_t e;
      if (expected_stats.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got %h", $time, got);
        return;
      end
      e = expected_stats.pop_front();
      cmp("mean_x", 64'(e.mean_x), 64'(got.mean_x));
      cmp("mean_y", 64'(e.mean_y), 64'(got.mean_y));
      cmp("mean_z", 64'(e.mean_z), 64'(got.mean_z));
      cmp("mean_nn_distance", 64'(e.mean_nn_distance), 64'(got.mean_nn_distance));
      cmp("equivalent_radius", 64'(e.equivalent_radius), 64'(got.equivalent_radius));
      cmp("scattering", 64'(e.scattering), 64'(got.scattering));
      cmp("point_count", 64'(e.point_count), 64'(got.point_count));
      cmp("overflowed", 64'(e.overflowed), 64'(got.overflowed));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  pcss_pkg::point_t               point;
  logic                           cfg_we;
  logic [pcss_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [pcss_pkg::DATA_W-1:0]    cfg_data;
  logic                           result_valid;
  pcss_pkg::result_t              result;

  cluster_scoreboard sb;
  int idle_pct;
  int wdog;

  point_cluster_spread_stats u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .point(point),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Monitor: results checked before a new point is noted; watchdog on idle cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(result);
      if (start && !busy) sb.note_point(point);
      if (result_valid || (start && !busy)) wdog = 0;
      else wdog++;
      if (wdog >= WDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // One point transfer; busy only moves on rising edges, so it is stable here
  task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                            logic signed [31:0] z, bit last);
    @(negedge clk);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    start <= 1'b1;
    point <= '{pos_x: x, pos_y: y, pos_z: z, last_point: last};
    while (busy) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(logic [pcss_pkg::CFG_IDX_W-1:0] idx,
                           logic [pcss_pkg::DATA_W-1:0] data);
    @(negedge clk);
    start     <= 1'b0;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.set_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.expected_stats.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coord(logic [31:0] base);
    case ($urandom_range(6))
      0, 1: return $urandom;
      2:    return $urandom_range(2000) - 1000;
      3:    return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return base + ($urandom_range(4096) - 2048);
    endcase
  endfunction

  task automatic random_clusters(int budget);
    int sent, n;
    logic [31:0] bx, by, bz;
    sent = 0;
    while (sent < budget) begin
      n  = ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 8);
      bx = $urandom; by = $urandom; bz = $urandom;
      for (int i = 0; i < n; i++) begin
        if (i > 0 && $urandom_range(15) == 0)
          send_point(point.pos_x, point.pos_y, point.pos_z, i == n - 1); // duplicate
        else
          send_point(pick_coord(bx), pick_coord(by), pick_coord(bz), i == n - 1);
      end
      sent += n;
    end
  endtask

  initial begin
    logic [pcss_pkg::SCALE_W-1:0] scales [5];
    logic [pcss_pkg::RAD_W-1:0]   scats  [5];
    int                           idles  [5];
    sb = new();
    rst = 1'b1; start = 1'b0; point = '0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    idle_pct = 0; wdog = 0;
    scales = '{16'd256, 16'd0, 16'hffff, 16'($urandom), 16'd1};
    scats  = '{48'd0, pcss_pkg::SAT48, 48'($urandom), {16'($urandom), 32'($urandom)}, 48'd1};
    idles  = '{0, 62, 17, 0, 62};
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 5; ph++) begin
      write_reg(pcss_pkg::REG_RADIUS_SCALE, pcss_pkg::DATA_W'(scales[ph]));
      write_reg(pcss_pkg::REG_DEFAULT_SCAT, scats[ph]);
      idle_pct = idles[ph];
      if (ph == 0) begin
        // single points at the extremes and the origin, then a far apart pair, duplicates and a three-point cluster
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
        send_point(32'h0, 32'h0, 32'h0, 1);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
        repeat (3) send_point(32'h0001_0000, -32'sh0002_0000, 32'h1234, 0);
        send_point(32'h0001_0000, -32'sh0002_0000, 32'h1234, 1);
        send_point(-32'sd3, 32'd5, -32'sd7, 0);
        send_point(32'd3, -32'sd5, 32'd7, 0);
        send_point(-32'sd1, 32'd0, 32'd1, 1);
      end
      if (ph == 1) begin
        // capacity reached: two points dropped, the last of them closing
        for (int i = 0; i < CAPACITY + 2; i++)
          send_point($urandom, $urandom, $urandom, i == CAPACITY + 1);
      end
      random_clusters(135);
      drain();
    end

    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hdl/pcss_pkg.sv
hdl/pcss_point_ram.sv
hdl/pcss_divider.sv
hdl/pcss_sqrt.sv
hdl/pcss_front.sv
hdl/pcss_back.sv
hdl/point_cluster_spread_stats.sv
dv/tb_top.sv
